// ===== design/nsl_pkg.sv =====
// ----------------------------------------------------------------------------
// nsl_pkg: shared types and constants for the note sequence lock
// Beat payloads, register indexes, reset values and the white-key table.
// ----------------------------------------------------------------------------
package nsl_pkg;

  // Default sizes handed to the top level
  localparam int NumSoundsDef   = 29;
  localparam int MaxSequenceDef = 8;

  // Configuration port
  localparam int CfgDataW = 56;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_SEQ_NOTES  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SEQ_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_BASE_NOTE  = 2'd3;

  // Register reset values
  localparam logic [55:0] SEQ_NOTES_RST  = 56'd0;
  localparam logic [3:0]  SEQ_LENGTH_RST = 4'd8;
  localparam logic [15:0] TIMEOUT_RST    = 16'd625;
  localparam logic [6:0]  BASE_NOTE_RST  = 7'd36;

  // Item opcodes and MIDI status
  localparam logic OP_MIDI = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic [3:0] STATUS_NOTE_ON = 4'h9;

  // Semitone offset of each white key inside one octave
  localparam logic [3:0] WHITE_OFFSET [7] = '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11};

  // Input beat
  typedef struct packed {
    logic       opcode;
    logic [7:0] status_byte;
    logic [6:0] midi_note;
  } item_t;

  // Result beat
  typedef struct packed {
    logic       note_on;
    logic       stop_previous;
    logic       sound_found;
    logic [4:0] sound_index;
    logic [2:0] match_count;
    logic       sequence_done;
    logic       timed_out;
  } result_t;

  // Semitone distance of white key k above the base note
  function automatic logic [6:0] key_offset(input int k);
    int         oct;
    logic [2:0] pos;
    oct = k / 7;
    pos = 3'(k % 7);
    return 7'(oct * 12 + int'(WHITE_OFFSET[pos]));
  endfunction

endpackage

// ===== design/nsl_if.sv =====
// ----------------------------------------------------------------------------
// nsl_if: valid/ready channels of the note sequence lock
// One channel for input items and one for result beats.
// ----------------------------------------------------------------------------
interface nsl_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] status_byte;
  logic [6:0] midi_note;

  modport source (output valid, output opcode, output status_byte,
                  output midi_note, input ready);
  modport sink   (input valid, input opcode, input status_byte,
                  input midi_note, output ready);
endinterface

interface nsl_out_if;
  logic       valid;
  logic       ready;
  logic       note_on;
  logic       stop_previous;
  logic       sound_found;
  logic [4:0] sound_index;
  logic [2:0] match_count;
  logic       sequence_done;
  logic       timed_out;

  modport source (output valid, output note_on, output stop_previous,
                  output sound_found, output sound_index, output match_count,
                  output sequence_done, output timed_out, input ready);
  modport sink   (input valid, input note_on, input stop_previous,
                  input sound_found, input sound_index, input match_count,
                  input sequence_done, input timed_out, output ready);
endinterface

// ===== design/nsl_key_map.sv =====
// ----------------------------------------------------------------------------
// nsl_key_map: note number to white-key sound index
// Compares the distance above the base note with every key offset in parallel.
// ----------------------------------------------------------------------------
module nsl_key_map #(
  parameter int NumSounds = nsl_pkg::NumSoundsDef
) (
  input  logic [6:0] note_i,
  input  logic [6:0] base_note_i,
  output logic       found_o,
  output logic [4:0] index_o
);
  import nsl_pkg::*;

  logic [7:0] diff;

  // Distance above the base; top bit set means the note lies below it
  assign diff = {1'b0, note_i} - {1'b0, base_note_i};

  // Keys have distinct offsets, so at most one compare hits
  always_comb begin
    found_o = 1'b0;
    index_o = '0;
    for (int k = 0; k < NumSounds; k++) begin
      if (!diff[7] && diff[6:0] == key_offset(k)) begin
        found_o = 1'b1;
        index_o = 5'(k);
      end
    end
  end

endmodule

// ===== design/nsl_seq_match.sv =====
// ----------------------------------------------------------------------------
// nsl_seq_match: sequence match, timeout and sound state
// Holds the lock state and updates it once per item leaving the input stage.
// ----------------------------------------------------------------------------
module nsl_seq_match #(
  parameter int MaxSequence = nsl_pkg::MaxSequenceDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        is_tick_i,
  input  logic        is_note_on_i,
  input  logic [6:0]  note_i,
  input  logic        sound_found_i,
  input  logic [55:0] seq_notes_i,
  input  logic [3:0]  seq_length_i,
  input  logic [15:0] timeout_ticks_i,
  output logic        stop_previous_o,
  output logic [2:0]  match_count_o,
  output logic        sequence_done_o,
  output logic        timed_out_o
);
  import nsl_pkg::*;

  logic [2:0]  pos_q, pos_d;
  logic        active_q, active_d;
  logic [15:0] ticks_q, ticks_d;
  logic        playing_q, playing_d;

  logic [3:0] eff_len;
  logic [3:0] pos_inc;
  logic [5:0] tgt_lsb;
  logic [6:0] target;
  logic       hit;

  // Length in use: zero reads as one, saturates at the maximum
  always_comb begin
    eff_len = seq_length_i;
    if (eff_len == 4'd0) begin
      eff_len = 4'd1;
    end
    if (eff_len > 4'(MaxSequence)) begin
      eff_len = 4'(MaxSequence);
    end
  end

  // Lowest bit of the target entry at the current position
  assign tgt_lsb = 6'(pos_q) * 6'd7;
  assign target  = seq_notes_i[tgt_lsb +: 7];
  assign hit     = (note_i == target);
  assign pos_inc = {1'b0, pos_q} + 4'd1;

  // Next state and result flags
  always_comb begin
    pos_d           = pos_q;
    active_d        = active_q;
    ticks_d         = ticks_q;
    playing_d       = playing_q;
    sequence_done_o = 1'b0;
    timed_out_o     = 1'b0;
    stop_previous_o = 1'b0;
    if (is_tick_i) begin
      if (active_q) begin
        if (ticks_q <= 16'd1) begin
          active_d    = 1'b0;
          ticks_d     = '0;
          pos_d       = '0;
          timed_out_o = 1'b1;
        end else begin
          ticks_d = ticks_q - 16'd1;
        end
      end
    end else if (is_note_on_i) begin
      stop_previous_o = playing_q;
      playing_d       = sound_found_i;
      if (hit) begin
        active_d = 1'b1;
        ticks_d  = timeout_ticks_i;
        if (pos_inc >= eff_len) begin
          pos_d           = '0;
          sequence_done_o = 1'b1;
        end else begin
          pos_d = pos_inc[2:0];
        end
      end else begin
        active_d = 1'b0;
        ticks_d  = '0;
        pos_d    = '0;
      end
    end
  end

  assign match_count_o = pos_d;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      active_q  <= 1'b0;
      ticks_q   <= '0;
      playing_q <= 1'b0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      active_q  <= active_d;
      ticks_q   <= ticks_d;
      playing_q <= playing_d;
    end
  end

  // Checks
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < 4'(MaxSequence))
    else $error("match position beyond sequence maximum");

  a_idle_no_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> ticks_q == 16'd0)
    else $error("ticks left while timeout idle");

  a_expire_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && timed_out_o |=> pos_q == 3'd0 && !active_q)
    else $error("expiry did not rewind the match");

endmodule

// ===== design/note_sequence_lock.sv =====
// ----------------------------------------------------------------------------
// note_sequence_lock: MIDI note-sequence combination lock with timeout
// Input stage, key mapping and sequence match, registered result stage.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled: a MIDI message or
// a timer tick. Every item gives exactly one result beat through the input
// register and then the result register. Items flow back to back at one per
// cycle when not stalled; the rate is set by the lock state (match position,
// timeout counter, sound flag), read and rewritten as an item moves from the
// input register to the result register. Configuration registers are written
// through the plain write port and must only change while no item is in flight.
module note_sequence_lock #(
  parameter int NumSounds   = nsl_pkg::NumSoundsDef,
  parameter int MaxSequence = nsl_pkg::MaxSequenceDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nsl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [nsl_pkg::CfgDataW-1:0]  cfg_wdata_i,
  nsl_in_if.sink                        in_i,
  nsl_out_if.source                     out_o
);
  import nsl_pkg::*;

  // Configuration registers
  logic [55:0] seq_notes_q;
  logic [3:0]  seq_length_q;
  logic [15:0] timeout_q;
  logic [6:0]  base_note_q;

  // Pipeline registers
  logic    in_valid_q, in_valid_d;
  item_t   in_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q, out_res_d;

  logic in_take;
  logic out_free;
  logic advance;
  logic is_tick;
  logic is_note_on;
  logic found;
  logic [4:0] index;
  logic stop_prev;
  logic [2:0] match_count;
  logic seq_done;
  logic timed_out;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_notes_q  <= SEQ_NOTES_RST;
      seq_length_q <= SEQ_LENGTH_RST;
      timeout_q    <= TIMEOUT_RST;
      base_note_q  <= BASE_NOTE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SEQ_NOTES:  seq_notes_q  <= cfg_wdata_i[55:0];
        CFG_SEQ_LENGTH: seq_length_q <= cfg_wdata_i[3:0];
        CFG_TIMEOUT:    timeout_q    <= cfg_wdata_i[15:0];
        CFG_BASE_NOTE:  base_note_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  // Input stage
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= '{opcode:      in_i.opcode,
                     status_byte: in_i.status_byte,
                     midi_note:   in_i.midi_note};
    end
  end

  // Item decode
  assign is_tick    = (in_item_q.opcode == OP_TICK);
  assign is_note_on = (in_item_q.opcode == OP_MIDI) &&
                      (in_item_q.status_byte[7:4] == STATUS_NOTE_ON);

  nsl_key_map #(
    .NumSounds (NumSounds)
  ) u_key_map (
    .note_i      (in_item_q.midi_note),
    .base_note_i (base_note_q),
    .found_o     (found),
    .index_o     (index)
  );

  nsl_seq_match #(
    .MaxSequence (MaxSequence)
  ) u_seq_match (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .is_tick_i       (is_tick),
    .is_note_on_i    (is_note_on),
    .note_i          (in_item_q.midi_note),
    .sound_found_i   (found),
    .seq_notes_i     (seq_notes_q),
    .seq_length_i    (seq_length_q),
    .timeout_ticks_i (timeout_q),
    .stop_previous_o (stop_prev),
    .match_count_o   (match_count),
    .sequence_done_o (seq_done),
    .timed_out_o     (timed_out)
  );

  // Result beat
  always_comb begin
    out_res_d.note_on       = is_note_on;
    out_res_d.stop_previous = stop_prev;
    out_res_d.sound_found   = is_note_on && found;
    out_res_d.sound_index   = is_note_on ? index : 5'd0;
    out_res_d.match_count   = match_count;
    out_res_d.sequence_done = seq_done;
    out_res_d.timed_out     = timed_out;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= out_res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.note_on       = out_res_q.note_on;
  assign out_o.stop_previous = out_res_q.stop_previous;
  assign out_o.sound_found   = out_res_q.sound_found;
  assign out_o.sound_index   = out_res_q.sound_index;
  assign out_o.match_count   = out_res_q.match_count;
  assign out_o.sequence_done = out_res_q.sequence_done;
  assign out_o.timed_out     = out_res_q.timed_out;

  // Checks
  a_done_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.sequence_done |-> out_res_q.match_count == 3'd0)
    else $error("sequence done without rewind");

  a_sound_needs_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_res_q.sound_found || out_res_q.stop_previous)
      |-> out_res_q.note_on)
    else $error("sound flags on a beat that is not a note-on");

  a_expire_is_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.timed_out
      |-> !out_res_q.note_on && out_res_q.match_count == 3'd0)
    else $error("timeout on a note beat or without rewind");

endmodule
